[sv/dqc_pkg.sv]
// Shared types and constants for the DNS query classifier.
`default_nettype none
package dqc_pkg;
	localparam int HEADER_BYTES = 12;
	localparam int OFF_W = $clog2(HEADER_BYTES + 1);

	localparam logic [2:0] PH_HEADER   = 3'd0;
	localparam logic [2:0] PH_NAME_LEN = 3'd1;
	localparam logic [2:0] PH_NAME_DAT = 3'd2;
	localparam logic [2:0] PH_TAIL     = 3'd3;
	localparam logic [2:0] PH_DONE     = 3'd4;
	localparam logic [2:0] PH_FAILSAFE = 3'd5;
	localparam logic [2:0] PH_EMPTY    = 3'd6;

	localparam logic [7:0] OPT_TYPE   = 8'd41;
	localparam logic [7:0] A_TYPE_LOW = 8'd1;
	localparam logic [7:0] CHAR_W     = 8'h77;
	localparam logic [7:0] CHAR_DOT   = 8'h2E;
	localparam logic [7:0] CHAR_UA    = 8'h41;
	localparam logic [7:0] CHAR_UZ    = 8'h5A;
	localparam logic [7:0] CASE_DELTA = 8'h20;

	typedef struct packed {
		logic       valid;
		logic       verdict;
		logic [7:0] qlen;
		logic [7:0] nlen;
	} res_t;
endpackage
`default_nettype wire

[sv/dqc_parser.sv]
// Per-byte header, QNAME and tail parser with its parse state.
`default_nettype none
module dqc_parser #(
	parameter int MAX_NAME_POS = 254
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step,
	input  wire logic [7:0]  data,
	input  wire logic        last,
	output dqc_pkg::res_t    res
);
	import dqc_pkg::*;

	localparam logic [8:0] MAX_POS = 9'(MAX_NAME_POS);

	logic [OFF_W-1:0] off_q, off_d;
	logic             hok_q, hok_d;
	logic             resp_q, resp_d;
	logic             hi_nz_q, hi_nz_d;
	logic             ext_one_q, ext_one_d;
	logic [2:0]       ph_q, ph_d;
	logic [7:0]       lrem_q, lrem_d;
	logic [7:0]       pos_q, pos_d;
	logic [7:0]       cc_q, cc_d;
	logic [1:0]       pm_q, pm_d;
	logic             tok_q, tok_d;
	logic [8:0]       next_pos;
	logic [7:0]       tail_cnt;
	logic [9:0]       fed;
	logic [7:0]       need;

	// returns {prefix_match, clean_count} after one name character
	function automatic logic [9:0] feed(input logic [7:0] c, input logic [1:0] pm,
			input logic [7:0] cc);
		logic [7:0] lc;
		logic [1:0] pm_n;
		logic [7:0] cc_n;
		lc = (c >= CHAR_UA && c <= CHAR_UZ) ? c + CASE_DELTA : c;
		if (lc == CHAR_W) begin
			pm_n = (pm < 2'd3) ? pm + 2'd1 : pm;
			cc_n = cc + 8'd1;
		end else if (lc == CHAR_DOT && pm == 2'd3) begin
			// drop the three counted w and this dot
			pm_n = 2'd0;
			cc_n = cc - 8'd3;
		end else begin
			pm_n = 2'd0;
			cc_n = cc + 8'd1;
		end
		return {pm_n, cc_n};
	endfunction

	always_comb begin
		off_d     = (off_q < OFF_W'(HEADER_BYTES)) ? off_q + OFF_W'(1) : off_q;
		hok_d     = hok_q;
		resp_d    = resp_q;
		hi_nz_d   = hi_nz_q;
		ext_one_d = ext_one_q;
		ph_d      = ph_q;
		lrem_d    = lrem_q;
		pos_d     = pos_q;
		cc_d      = cc_q;
		pm_d      = pm_q;
		tok_d     = tok_q;
		next_pos  = {1'b0, pos_q} + {1'b0, data} + 9'd1;
		tail_cnt  = lrem_q + 8'd1;
		fed       = 10'd0;
		unique case (ph_q)
			PH_HEADER: begin
				unique case (off_q)
					OFF_W'(2): begin
						resp_d = data[7];
						if (data[6:3] != 4'd0) hok_d = 1'b0;
					end
					OFF_W'(4), OFF_W'(6), OFF_W'(7), OFF_W'(8), OFF_W'(9): begin
						if (data != 8'd0) hok_d = 1'b0;
					end
					OFF_W'(5): begin
						if (data != 8'd1) hok_d = 1'b0;
					end
					OFF_W'(10): begin
						hi_nz_d = (data != 8'd0);
					end
					OFF_W'(11): begin
						ext_one_d = !hi_nz_q && data == 8'd1;
						if (hi_nz_q || data > 8'd1) hok_d = 1'b0;
						ph_d  = PH_NAME_LEN;
						pos_d = 8'd0;
					end
					default: ;
				endcase
			end
			PH_NAME_LEN: begin
				if (data == 8'd0) begin
					if (pos_q == 8'd0) begin
						ph_d = PH_EMPTY;
					end else begin
						ph_d   = PH_TAIL;
						lrem_d = 8'd0;
						tok_d  = 1'b1;
					end
				end else if (next_pos > MAX_POS) begin
					ph_d = PH_FAILSAFE;
				end else begin
					if (pos_q != 8'd0) begin
						fed  = feed(CHAR_DOT, pm_q, cc_q);
						pm_d = fed[9:8];
						cc_d = fed[7:0];
					end
					lrem_d = data;
					pos_d  = next_pos[7:0];
					ph_d   = PH_NAME_DAT;
				end
			end
			PH_NAME_DAT: begin
				fed    = feed(data, pm_q, cc_q);
				pm_d   = fed[9:8];
				cc_d   = fed[7:0];
				lrem_d = (lrem_q != 8'd0) ? lrem_q - 8'd1 : lrem_q;
				if (lrem_d == 8'd0) ph_d = PH_NAME_LEN;
			end
			PH_TAIL: begin
				lrem_d = tail_cnt;
				unique case (tail_cnt)
					8'd2: if (data != A_TYPE_LOW) tok_d = 1'b0;
					8'd5, 8'd6: if (ext_one_q && data != 8'd0) tok_d = 1'b0;
					8'd7: if (ext_one_q && data != OPT_TYPE) tok_d = 1'b0;
					default: ;
				endcase
				if (tail_cnt >= 8'd7) ph_d = PH_DONE;
			end
			default: ;
		endcase
	end

	// verdict from the state as it stands after this byte
	always_comb begin
		need        = ext_one_d ? 8'd7 : 8'd2;
		res.valid   = step && last && off_q >= OFF_W'(HEADER_BYTES - 1) && !resp_d;
		res.verdict = 1'b1;
		res.qlen    = 8'd0;
		res.nlen    = 8'd0;
		if (ph_d == PH_FAILSAFE) begin
			res.qlen = 8'd1;
		end else if (ph_d == PH_TAIL || ph_d == PH_DONE) begin
			res.qlen = pos_d + 8'd1;
			res.nlen = cc_d;
			if (hok_d && tok_d && lrem_d >= need && cc_d > 8'd1) res.verdict = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q     <= '0;
			hok_q     <= 1'b1;
			resp_q    <= 1'b0;
			hi_nz_q   <= 1'b0;
			ext_one_q <= 1'b0;
			ph_q      <= PH_HEADER;
			lrem_q    <= 8'd0;
			pos_q     <= 8'd0;
			cc_q      <= 8'd0;
			pm_q      <= 2'd0;
			tok_q     <= 1'b0;
		end else if (step) begin
			if (last) begin
				// end of request: back to the reset state
				off_q     <= '0;
				hok_q     <= 1'b1;
				resp_q    <= 1'b0;
				hi_nz_q   <= 1'b0;
				ext_one_q <= 1'b0;
				ph_q      <= PH_HEADER;
				lrem_q    <= 8'd0;
				pos_q     <= 8'd0;
				cc_q      <= 8'd0;
				pm_q      <= 2'd0;
				tok_q     <= 1'b0;
			end else begin
				off_q     <= off_d;
				hok_q     <= hok_d;
				resp_q    <= resp_d;
				hi_nz_q   <= hi_nz_d;
				ext_one_q <= ext_one_d;
				ph_q      <= ph_d;
				lrem_q    <= lrem_d;
				pos_q     <= pos_d;
				cc_q      <= cc_d;
				pm_q      <= pm_d;
				tok_q     <= tok_d;
			end
		end
	end

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		step && last |=> ph_q == PH_HEADER && off_q == '0)
		else $error("parser not restarted after final byte");
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, pos_q} <= MAX_POS)
		else $error("name position beyond failsafe limit");
	a_fwd_len: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.verdict |-> res.nlen > 8'd1 && res.qlen > 8'd1)
		else $error("forward verdict with too short a name");
endmodule
`default_nettype wire

[sv/dqc_out_reg.sv]
// Result register with valid/ready towards the consumer.
`default_nettype none
module dqc_out_reg (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  dqc_pkg::res_t      res,
	output logic               free,
	output logic               result_valid,
	input  wire logic          result_ready,
	output logic               verdict,
	output logic [7:0]         qname_length,
	output logic [7:0]         name_length
);
	import dqc_pkg::*;

	logic       valid_q;
	logic       verdict_q;
	logic [7:0] qlen_q;
	logic [7:0] nlen_q;

	assign free         = !valid_q || result_ready;
	assign result_valid = valid_q;
	assign verdict      = verdict_q;
	assign qname_length = qlen_q;
	assign name_length  = nlen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res.valid) begin
			valid_q <= 1'b1;
		end else if (result_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			verdict_q <= res.verdict;
			qlen_q    <= res.qlen;
			nlen_q    <= res.nlen;
		end
	end
endmodule
`default_nettype wire

[sv/dns_query_classifier.sv]
// An accepted byte is held in the input register, parsed from there, and its result is stored in the output register.
// Throughput: one payload byte per cycle while the result side is ready.
// The parse state updates with small counters and compares from a single registered byte.
// A result waiting in the output register stalls the input stage only when it is not taken.
// Reset (arst_n low, asynchronous) empties both registers and returns the parser to the header.
`default_nettype none
module dns_query_classifier #(
	parameter int MAX_NAME_POS = 254
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       byte_valid,
	output logic            byte_ready,
	input  wire logic [7:0] packet_byte,
	input  wire logic       last_byte,
	output logic            result_valid,
	input  wire logic       result_ready,
	output logic            verdict,
	output logic [7:0]      qname_length,
	output logic [7:0]      name_length
);
	import dqc_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       free;
	logic       step;
	res_t       res;

	assign step       = valid_s1 && free;
	assign byte_ready = !valid_s1 || free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			byte_s1 <= packet_byte;
			last_s1 <= last_byte;
		end
	end

	dqc_parser #(
		.MAX_NAME_POS(MAX_NAME_POS)
	) u_parser (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (step),
		.data  (byte_s1),
		.last  (last_s1),
		.res   (res)
	);

	dqc_out_reg u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.res         (res),
		.free        (free),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.verdict     (verdict),
		.qname_length(qname_length),
		.name_length (name_length)
	);

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !result_valid || result_ready)
		else $error("result produced over an untaken result");
endmodule
`default_nettype wire
